/* sv/cfd_pkg.sv */
// Shared types and constants for the command frame deframer.
`default_nettype none
package cfd_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 6;
   localparam int IDX_W     = 5;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int QDEPTH    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOOTER = 2'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd254;
   localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd250;

   typedef enum logic [2:0] {
      PH_HEAD1,
      PH_HEAD2,
      PH_LEN,
      PH_CMD,
      PH_DATA,
      PH_FOOT
   } phase_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_BADHEAD = 3'd1,
      ST_BADLEN  = 3'd2,
      ST_TOOLONG = 3'd3,
      ST_BADFOOT = 3'd4
   } status_type;

   // One queued outcome: an accepted frame or a framing error.
   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  command;
      logic [LEN_W-1:0]   plen;
   } desc_type;

endpackage
`default_nettype wire

/* sv/cfd_front.sv */
// Front end: config registers, frame parser and payload store writes.
`default_nettype none
module cfd_front #(
   parameter int MAX_PAYLOAD = 32,
   parameter int AW          = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfd_pkg::BYTE_W-1:0]    csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cfd_pkg::BYTE_W-1:0]    req_rx_byte,
   input  wire logic                          q_full,
   input  wire logic                          drain_done,
   output logic                               push,
   output cfd_pkg::desc_type                  push_desc,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output logic [cfd_pkg::BYTE_W-1:0]         wr_data
);
   import cfd_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] hdr_ff, ftr_ff, cmd_ff;
   logic [LEN_W-1:0]  exp_ff, cnt_ff;
   logic              busy_ff;
   logic              accept;
   logic [LEN_W-1:0]  cnt_next;
   logic              len_short, len_long;
   logic [BYTE_W:0]   len_minus2;

   assign csr_ready  = 1'b1;
   assign accept     = req_valid && req_ready;
   assign cnt_next   = cnt_ff + 1'b1;
   assign len_short  = req_rx_byte < 8'd2;
   assign len_minus2 = {1'b0, req_rx_byte} - 9'd2;
   assign len_long   = len_minus2 > (BYTE_W+1)'(MAX_PAYLOAD);

   // store writes are held off while an earlier frame is still draining
   assign req_ready = !q_full && !(phase_ff == PH_DATA && busy_ff);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEAD1: begin
               if (req_rx_byte == hdr_ff) phase_in = PH_HEAD2;
            end
            PH_HEAD2: begin
               phase_in = (req_rx_byte == hdr_ff) ? PH_LEN : PH_HEAD1;
            end
            PH_LEN: begin
               phase_in = (len_short || len_long) ? PH_HEAD1 : PH_CMD;
            end
            PH_CMD: begin
               phase_in = (exp_ff == '0) ? PH_FOOT : PH_DATA;
            end
            PH_DATA: begin
               if (cnt_next >= exp_ff) phase_in = PH_FOOT;
            end
            default: begin
               phase_in = PH_HEAD1;
            end
         endcase
      end
   end

   always_comb begin
      push              = 1'b0;
      push_desc.status  = ST_OK;
      push_desc.command = '0;
      push_desc.plen    = '0;
      wr_en             = 1'b0;
      wr_addr           = cnt_ff[AW-1:0];
      wr_data           = req_rx_byte;
      if (accept) begin
         case (phase_ff)
            PH_HEAD1, PH_HEAD2: begin
               if (req_rx_byte != hdr_ff) begin
                  push             = 1'b1;
                  push_desc.status = ST_BADHEAD;
               end
            end
            PH_LEN: begin
               if (len_short) begin
                  push             = 1'b1;
                  push_desc.status = ST_BADLEN;
               end else if (len_long) begin
                  push             = 1'b1;
                  push_desc.status = ST_TOOLONG;
               end
            end
            PH_DATA: begin
               wr_en = 1'b1;
            end
            PH_FOOT: begin
               push = 1'b1;
               if (req_rx_byte != ftr_ff) begin
                  push_desc.status = ST_BADFOOT;
               end else begin
                  push_desc.command = cmd_ff;
                  push_desc.plen    = exp_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         hdr_ff   <= HEADER_RESET;
         ftr_ff   <= FOOTER_RESET;
         busy_ff  <= 1'b0;
         exp_ff   <= '0;
         cnt_ff   <= '0;
         cmd_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEADER) hdr_ff <= csr_data;
            if (csr_index == CSR_FOOTER) ftr_ff <= csr_data;
         end
         if (push && push_desc.status == ST_OK && push_desc.plen != '0) begin
            busy_ff <= 1'b1;
         end else if (drain_done) begin
            busy_ff <= 1'b0;
         end
         if (accept && phase_ff == PH_LEN) exp_ff <= len_minus2[LEN_W-1:0];
         if (accept && phase_ff == PH_CMD) begin
            cmd_ff <= req_rx_byte;
            cnt_ff <= '0;
         end
         if (wr_en) cnt_ff <= cnt_next;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("descriptor pushed into a full queue");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (phase_ff == PH_DATA) && !busy_ff && (cnt_ff < exp_ff))
      else $error("payload store written while in use or past length");

endmodule
`default_nettype wire

/* sv/cfd_queue.sv */
// Short descriptor queue between the parser and the result stage.
`default_nettype none
module cfd_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire cfd_pkg::desc_type push_desc,
   input  wire logic        pop,
   output logic             full,
   output logic             empty,
   output cfd_pkg::desc_type head
);
   import cfd_pkg::*;

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   desc_type         entry_ff [QDEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [PW:0]      count_ff;

   assign full  = count_ff == (PW+1)'(QDEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= (wptr_ff == PW'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         if (pop)  rptr_ff <= (rptr_ff == PW'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

/* sv/cfd_back.sv */
// Back end: payload store and result delivery through an output register.
`default_nettype none
module cfd_back #(
   parameter int MAX_PAYLOAD = 32,
   parameter int AW          = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   input  wire cfd_pkg::desc_type           q_head,
   output logic                             pop,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [cfd_pkg::BYTE_W-1:0]  wr_data,
   output logic                             drain_done,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [cfd_pkg::STAT_W-1:0]       rsp_status,
   output logic [cfd_pkg::BYTE_W-1:0]       rsp_command,
   output logic [cfd_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic [cfd_pkg::IDX_W-1:0]        rsp_byte_index,
   output logic [cfd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic                             rsp_last
);
   import cfd_pkg::*;

   logic [BYTE_W-1:0] store_ff [MAX_PAYLOAD];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              valid_ff;
   status_type        status_ff;
   logic [BYTE_W-1:0] command_ff, byte_ff;
   logic [LEN_W-1:0]  plen_ff;
   logic [IDX_W-1:0]  bidx_ff;
   logic              last_ff;
   logic              out_free, load, single, is_last;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = out_free && !q_empty;
   assign single   = (q_head.status != ST_OK) || (q_head.plen == '0);
   assign is_last  = single || ((LEN_W'(idx_ff) + 1'b1) == q_head.plen);
   assign pop      = load && is_last;
   assign drain_done = pop && !single;
   assign idx_in   = (load && !single) ? (is_last ? '0 : idx_ff + 1'b1) : idx_ff;

   // read address runs one step ahead so the registered data matches idx_ff
   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      rd_data_ff <= store_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= q_head.status;
         command_ff <= q_head.command;
         plen_ff    <= q_head.plen;
         bidx_ff    <= single ? '0 : IDX_W'(idx_ff);
         byte_ff    <= single ? '0 : rd_data_ff;
         last_ff    <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load)           valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_command        = command_ff;
   assign rsp_payload_length = plen_ff;
   assign rsp_byte_index     = bidx_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_last           = last_ff;

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_OK |-> last_ff && command_ff == '0 && byte_ff == '0)
      else $error("error result not a single cleared transfer");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> idx_ff == '0)
      else $error("payload index left mid-frame with no frame queued");

endmodule
`default_nettype wire

/* sv/command_frame_deframer.sv */
// Top level of the command frame deframer.
// Takes one received byte per transfer and parses frames: header, header,
// length L, command, L-2 payload bytes, footer. A good frame gives one
// result per payload byte (one result for an empty payload), the final one
// with last set; each framing error gives a single result with last set.
// Input bytes are taken, and results leave through the output register
// once the footer matches, one per cycle unless stalled. A payload byte of
// the next frame waits until the previous frame's payload store is fully
// read out; any byte waits while the two-entry descriptor queue is full.
// Header and footer values are written through the csr port (index 0 and 1).
`default_nettype none
module command_frame_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfd_pkg::BYTE_W-1:0]    csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cfd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cfd_pkg::STAT_W-1:0]         rsp_status,
   output logic [cfd_pkg::BYTE_W-1:0]         rsp_command,
   output logic [cfd_pkg::LEN_W-1:0]          rsp_payload_length,
   output logic [cfd_pkg::IDX_W-1:0]          rsp_byte_index,
   output logic [cfd_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                               rsp_last
);
   import cfd_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic              q_full, q_empty, push, pop, drain_done, wr_en;
   desc_type          push_desc, q_head;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;

   cfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .drain_done  (drain_done),
      .push        (push),
      .push_desc   (push_desc),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   cfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   cfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .pop                (pop),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .drain_done         (drain_done),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

/* dv/command_frame_deframer_tb.sv */
// Self-checking testbench for the command frame deframer: directed and random byte streams.
module command_frame_deframer_tb;
   import cfd_pkg::*;

   localparam int PAYLOAD_MAX   = 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_MAX    = 10;
   localparam int PHASE_BYTES   = 30;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef logic [BYTE_W-1:0] octet_type;

   typedef struct packed {
      status_type         status;
      octet_type          command;
      logic [LEN_W-1:0]   plen;
      logic [IDX_W-1:0]   index;
      octet_type          data;
      logic               last;
   } frame_result_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   octet_type            csr_data    = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   octet_type            req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   octet_type            rsp_command;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [IDX_W-1:0]     rsp_byte_index;
   octet_type            rsp_payload_byte;
   logic                 rsp_last;

   // parser mirror
   octet_type        header_byte  = HEADER_RESET;
   octet_type        footer_byte  = FOOTER_RESET;
   phase_type        parse_phase  = PH_HEAD1;
   int               payload_want = 0;
   int               payload_got  = 0;
   octet_type        held_cmd     = '0;
   octet_type        payload_buf [PAYLOAD_MAX];
   frame_result_type pending_results [$];

   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold      = 1'b0;
   int   mismatches    = 0;
   int   cycle_count   = 0;
   int   bytes_sent    = 0;

   always #5 clock = ~clock;

   command_frame_deframer #(.MAX_PAYLOAD(PAYLOAD_MAX)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

   function automatic void queue_result(input status_type st, input octet_type cmd,
                                        input int plen, input int idx,
                                        input octet_type data, input logic last);
      frame_result_type r;
      r.status  = st;
      r.command = cmd;
      r.plen    = LEN_W'(plen);
      r.index   = IDX_W'(idx);
      r.data    = data;
      r.last    = last;
      pending_results.push_back(r);
   endfunction

   function automatic void flag_error(input status_type st);
      parse_phase = PH_HEAD1;
      queue_result(st, '0, 0, 0, '0, 1'b1);
   endfunction

   function automatic void parse_rx_byte(input octet_type b);
      case (parse_phase)
         PH_HEAD2: begin
            if (b != header_byte) flag_error(ST_BADHEAD);
            else parse_phase = PH_LEN;
         end
         PH_LEN: begin
            if (b < 2) flag_error(ST_BADLEN);
            else if (int'(b) - 2 > PAYLOAD_MAX) flag_error(ST_TOOLONG);
            else begin
               payload_want = int'(b) - 2;
               parse_phase  = PH_CMD;
            end
         end
         PH_CMD: begin
            held_cmd    = b;
            payload_got = 0;
            parse_phase = (payload_want == 0) ? PH_FOOT : PH_DATA;
         end
         PH_DATA: begin
            if (payload_got < PAYLOAD_MAX) payload_buf[payload_got] = b;
            payload_got++;
            if (payload_got >= payload_want) parse_phase = PH_FOOT;
         end
         PH_FOOT: begin
            if (b != footer_byte) flag_error(ST_BADFOOT);
            else begin
               parse_phase = PH_HEAD1;
               if (payload_want == 0) queue_result(ST_OK, held_cmd, 0, 0, '0, 1'b1);
               else begin
                  for (int i = 0; i < payload_want && i < PAYLOAD_MAX; i++)
                     queue_result(ST_OK, held_cmd, payload_want, i, payload_buf[i],
                                  i + 1 == payload_want);
               end
            end
         end
         default: begin
            if (b != header_byte) flag_error(ST_BADHEAD);
            else parse_phase = PH_HEAD2;
         end
      endcase
   endfunction

   task automatic send_byte(input octet_type b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input int plen, input octet_type cmd, input bit footer_ok);
      send_byte(header_byte);
      send_byte(header_byte);
      send_byte(octet_type'(plen + 2));
      send_byte(cmd);
      for (int i = 0; i < plen; i++) send_byte(octet_type'($urandom));
      send_byte(footer_ok ? footer_byte : footer_byte ^ octet_type'($urandom_range(1, 255)));
   endtask

   task automatic send_noise();
      int kind;
      kind = $urandom_range(4);
      case (kind)
         0: send_byte(octet_type'($urandom));
         1: begin
            send_byte(header_byte);
            send_byte(header_byte ^ octet_type'($urandom_range(1, 255)));
         end
         2: begin
            send_byte(header_byte);
            send_byte(header_byte);
            if ($urandom_range(1)) send_byte(octet_type'($urandom_range(1)));
            else send_byte(octet_type'($urandom_range(PAYLOAD_MAX + 3, 255)));
         end
         3: begin
            // frame cut short; later bytes land in its payload
            send_byte(header_byte);
            send_byte(header_byte);
            send_byte(octet_type'($urandom_range(3, 8)));
            send_byte(octet_type'($urandom));
         end
         default: send_frame($urandom_range(4), octet_type'($urandom), 1'b0);
      endcase
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input octet_type value,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
      if (idx == CSR_HEADER) header_byte = value;
      else if (idx == CSR_FOOTER) footer_byte = value;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(header_byte);
      send_byte(8'h00);
      send_byte(header_byte);
      send_byte(header_byte);
      send_byte(8'd0);
      send_byte(header_byte);
      send_byte(header_byte);
      send_byte(8'd1);
      send_byte(header_byte);
      send_byte(header_byte);
      send_byte(octet_type'(PAYLOAD_MAX + 3));
      send_frame(0, 8'hFF, 1'b1);
      send_frame(1, 8'h00, 1'b0);
   endtask

   task automatic test_spare_csr();
      wait_idle();
      write_csr(CSR_SPARE_LO, 8'h00, 1'b1);
      write_csr(CSR_SPARE_HI, 8'hFF, 1'b0);
      send_frame(2, 8'h5A, 1'b1);
   endtask

   task automatic test_traffic(input int idle_pct, input int stall_pct,
                               input octet_type hdr, input octet_type ftr);
      int stop_at;
      int plen;
      wait_idle();
      write_csr(CSR_HEADER, hdr, 1'b1);
      write_csr(CSR_FOOTER, ftr, 1'b0);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            plen = ($urandom_range(9) == 0) ? $urandom_range(PAYLOAD_MAX) : $urandom_range(6);
            send_frame(plen, octet_type'($urandom), $urandom_range(19) != 0);
         end else send_noise();
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (2) send_frame(PAYLOAD_MAX, octet_type'($urandom), 1'b1);
      repeat (4) send_frame($urandom_range(3), octet_type'($urandom), 1'b1);
   endtask

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: status %0d command %h length %0d index %0d",
                        rsp_status, rsp_command, rsp_payload_length, rsp_byte_index);
         end else begin
            want = pending_results.pop_front();
            if (want.status != rsp_status || want.command != rsp_command ||
                want.plen != rsp_payload_length || want.index != rsp_byte_index ||
                want.data != rsp_payload_byte || want.last != rsp_last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display(
                     "exp/got st %0d/%0d cmd %h/%h len %0d/%0d idx %0d/%0d byte %h/%h last %b/%b",
                     want.status, rsp_status, want.command, rsp_command,
                     want.plen, rsp_payload_length, want.index, rsp_byte_index,
                     want.data, rsp_payload_byte, want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_spare_csr();
      test_traffic(0, 0, 8'h00, 8'hFF);
      test_traffic(71, 0, 8'hFF, 8'h00);
      test_traffic(0, 71, 8'hA5, 8'hA5);
      test_traffic(28, 28, octet_type'($urandom), octet_type'($urandom));
      test_backpressure();
      wait_idle();
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
sv/cfd_pkg.sv
sv/cfd_front.sv
sv/cfd_queue.sv
sv/cfd_back.sv
sv/command_frame_deframer.sv
dv/command_frame_deframer_tb.sv
